FILE: hw/rtl/stll_pkg.sv
// Shared types and constants for the sorted table level lookup block.
`timescale 1ns / 1ps

package stll_pkg;

  // Table geometry
  localparam int NUM_TABLES  = 8;
  localparam int TABLE_LEN   = 128;
  localparam int QUEUE_DEPTH = 2;

  // Search and result constants
  localparam logic [6:0]  START_INDEX  = 7'h40;
  localparam logic [5:0]  START_STEP   = 6'h20;
  localparam logic [6:0]  TOP_LEVEL    = 7'h62;
  localparam logic [6:0]  CLAMP_LIMIT  = 7'h63;
  localparam logic [31:0] TOP_SUBLEVEL = 32'h30;
  localparam logic [31:0] SUBLEVEL_MUL = 32'd49;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // One input beat
  typedef struct packed {
    op_e                operation;
    logic [2:0]         table_select;
    logic [6:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_value;
  } req_t;

  // One result beat
  typedef struct packed {
    logic [6:0]         level;
    logic signed [31:0] distance;
    logic signed [31:0] sublevel;
    logic signed [31:0] overflow;
  } rsp_t;

endpackage

FILE: hw/rtl/stll_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stll_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/stll_fifo.sv
// Short beat queue between the front end and the search engine.
`timescale 1ns / 1ps

module stll_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stll_pkg::req_t data_i,
  input  logic          pop_i,
  output stll_pkg::req_t data_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int PtrW = (stll_pkg::QUEUE_DEPTH > 1) ? $clog2(stll_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(stll_pkg::QUEUE_DEPTH + 1);

  stll_pkg::req_t  mem_q [stll_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(stll_pkg::QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(stll_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(stll_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/stll_div.sv
// Bit-serial signed 32-bit divider, truncating, one quotient bit per cycle.
`timescale 1ns / 1ps

module stll_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q, done_q, neg_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, dmag_q;
  logic [32:0] shifted, diff;

  // One restoring step
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitudes in, sign fixed on the way out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= num_i[31] ? 32'(-num_i) : num_i;
      dmag_q <= den_i[31] ? 32'(-den_i) : den_i;
      neg_q  <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? 32'(-quo_q) : quo_q;

endmodule

FILE: hw/rtl/stll_engine.sv
// Back end: table loads, binary search, neighbor fetch and result assembly.
`timescale 1ns / 1ps

module stll_engine #(
  parameter int NumTables = stll_pkg::NUM_TABLES,
  parameter int AddrW     = $clog2(NumTables * stll_pkg::TABLE_LEN)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stll_pkg::req_t   item_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [31:0]      ram_wdata_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [31:0]      ram_rdata_i,
  output logic             result_valid_o,
  output stll_pkg::rsp_t   rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_HI_RD, S_HI_CMP, S_LO_RD, S_LO_CMP, S_FIN, S_PREV_RD, S_CUR_RD,
    S_NXT_RD, S_NXT_GOT, S_MUL, S_DIV, S_DIV_WAIT, S_OUT
  } state_e;

  state_e         state_q;
  stll_pkg::req_t item_q;
  logic [6:0]     index_q, level_q, pos, lvl_m1;
  logic [5:0]     step_q;
  logic [31:0]    prev_q, cur_q, nxt_q, num_q, den_q;
  logic           valid_q, div_start_q, div_done;
  logic [31:0]    div_quo;
  stll_pkg::rsp_t rsp_q;
  logic           take;

  assign take   = (state_q == S_IDLE) && !empty_i;
  assign pop_o  = take;
  assign lvl_m1 = index_q - 7'd1;

  // Loads write straight from the queue head
  assign ram_we_o    = take && (item_i.operation == stll_pkg::OP_LOAD);
  assign ram_waddr_o = AddrW'({item_i.table_select, item_i.entry_index});
  assign ram_wdata_o = item_i.entry_value;

  // Read position by state
  always_comb begin
    case (state_q)
      S_LO_RD:   pos = index_q - 7'd1;
      S_PREV_RD: pos = (level_q == '0) ? level_q : level_q - 7'd1;
      S_CUR_RD:  pos = level_q;
      S_NXT_RD:  pos = level_q + 7'd1;
      default:   pos = index_q;
    endcase
  end
  assign ram_raddr_o = AddrW'({item_q.table_select, pos});

  stll_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequencer with registered result outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= 1'b0;
      div_start_q <= 1'b0;
      index_q     <= '0;
      step_q      <= '0;
      level_q     <= '0;
      item_q      <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      nxt_q       <= '0;
      num_q       <= '0;
      den_q       <= '0;
      rsp_q       <= '0;
    end else begin
      valid_q     <= 1'b0;
      div_start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            item_q  <= item_i;
            index_q <= stll_pkg::START_INDEX;
            step_q  <= stll_pkg::START_STEP;
            if (item_i.operation == stll_pkg::OP_QUERY) begin
              state_q <= S_HI_RD;
            end
          end
        end
        S_HI_RD: state_q <= S_HI_CMP;
        S_HI_CMP: begin
          if (item_q.query_value >= $signed(ram_rdata_i)) begin
            index_q <= index_q + 7'(step_q);
            step_q  <= step_q >> 1;
            state_q <= (step_q == 6'd1) ? S_FIN : S_HI_RD;
          end else begin
            state_q <= S_LO_RD;
          end
        end
        S_LO_RD: state_q <= S_LO_CMP;
        S_LO_CMP: begin
          if (item_q.query_value < $signed(ram_rdata_i)) begin
            index_q <= index_q - 7'(step_q);
            step_q  <= step_q >> 1;
            state_q <= (step_q == 6'd1) ? S_FIN : S_HI_RD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          level_q <= (lvl_m1 < stll_pkg::CLAMP_LIMIT) ? lvl_m1 : stll_pkg::TOP_LEVEL;
          state_q <= S_PREV_RD;
        end
        S_PREV_RD: state_q <= S_CUR_RD;
        S_CUR_RD: begin
          prev_q  <= ram_rdata_i;
          state_q <= S_NXT_RD;
        end
        S_NXT_RD: begin
          cur_q   <= ram_rdata_i;
          state_q <= S_NXT_GOT;
        end
        S_NXT_GOT: begin
          nxt_q   <= ram_rdata_i;
          state_q <= S_MUL;
        end
        S_MUL: begin
          num_q   <= 32'((item_q.query_value - cur_q) * stll_pkg::SUBLEVEL_MUL);
          den_q   <= nxt_q - cur_q;
          state_q <= (level_q != stll_pkg::TOP_LEVEL && nxt_q != cur_q) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          div_start_q <= 1'b1;
          state_q     <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          valid_q        <= 1'b1;
          rsp_q.level    <= level_q;
          rsp_q.overflow <= (level_q == '0) ? '0 : item_q.query_value - prev_q;
          if (level_q == stll_pkg::TOP_LEVEL) begin
            rsp_q.distance <= '0;
            rsp_q.sublevel <= stll_pkg::TOP_SUBLEVEL;
          end else begin
            rsp_q.distance <= nxt_q - item_q.query_value;
            rsp_q.sublevel <= (den_q == '0) ? '0 : div_quo;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  // A result beat only follows the final assembly step
  a_valid_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q) == S_OUT)
    else $error("result beat without assembly step");

  // Search never issues a read with the step exhausted
  a_step_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HI_RD || state_q == S_LO_RD) |-> step_q != '0)
    else $error("search read with zero step");

  // Level stays clamped once fixed
  a_level_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> level_q <= stll_pkg::TOP_LEVEL)
    else $error("level above clamp");

  // Divider completes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT)
    else $error("divider done out of place");

endmodule

FILE: hw/rtl/sorted_table_level_lookup.sv
// Load/query: a query is binary-searched, then fetches neighbors, divides when needed, reports.
// A load is written to the table RAM from the queue head once the engine is idle; a query yields
// its result beat after its search reads, the neighbor fetch and product, and the 32-step
// bit-serial divider when the fraction needs one. busy: 2-entry queue full.
// Throughput: loads one per cycle while the engine idles; a query holds it until it reports.
// Reset clears all control state; table contents are undefined until written.
`timescale 1ns / 1ps

module sorted_table_level_lookup #(
  parameter int NumTables = stll_pkg::NUM_TABLES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  stll_pkg::req_t req_i,
  output logic           result_valid_o,
  output stll_pkg::rsp_t rsp_o
);

  localparam int Depth = NumTables * stll_pkg::TABLE_LEN;
  localparam int AddrW = $clog2(Depth);

  logic             accept, in_range, full, empty, pop;
  stll_pkg::req_t   head;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;

  // Front end: take beats, drop those for absent tables
  assign busy     = full;
  assign accept   = start && !busy;
  assign in_range = ({4'b0, req_i.table_select} < 7'(NumTables));

  stll_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && in_range),
    .data_i  (req_i),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  stll_engine #(
    .NumTables (NumTables),
    .AddrW     (AddrW)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  stll_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: bench/sorted_table_level_lookup_tb.sv
// Self-checking testbench for the sorted table level lookup block.
`timescale 1ns / 1ps

module sorted_table_level_lookup_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  stll_pkg::req_t req_i = '0;
  logic result_valid_o;
  stll_pkg::rsp_t rsp_o;

  sorted_table_level_lookup u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .result_valid_o(result_valid_o),
    .rsp_o(rsp_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow of the threshold tables, updated as loads are accepted
  logic [31:0] thresh_shadow [stll_pkg::NUM_TABLES][stll_pkg::TABLE_LEN];
  // Plan of table contents, used to build load values and to steer query values
  logic [31:0] thresh_plan [stll_pkg::NUM_TABLES][stll_pkg::TABLE_LEN];

  stll_pkg::req_t pending_beats[$];
  stll_pkg::rsp_t expected_levels[$];
  int   mismatch_count = 0;
  int   load_count = 0;
  int   query_count = 0;
  int   result_count = 0;
  int   idle_cycles = 0;

  // Level search and interpolation for one query
  function automatic stll_pkg::rsp_t classify_value(input logic [2:0] tab,
                                                    input logic [31:0] qv);
    stll_pkg::rsp_t r;
    logic [6:0] index;
    logic [5:0] step;
    logic [6:0] lvl;
    logic [31:0] cur;
    logic [31:0] nxt;
    logic [31:0] num;
    logic [31:0] den;
    index = stll_pkg::START_INDEX;
    step  = stll_pkg::START_STEP;
    while (step != 0) begin
      if ($signed(qv) >= $signed(thresh_shadow[tab][index])) begin
        index = index + 7'(step);
      end else if ($signed(qv) < $signed(thresh_shadow[tab][index - 7'd1])) begin
        index = index - 7'(step);
      end else begin
        step = '0;
      end
      step = step >> 1;
    end
    index = index - 7'd1;
    lvl = (index < stll_pkg::CLAMP_LIMIT) ? index : stll_pkg::TOP_LEVEL;
    r.level    = lvl;
    r.distance = '0;
    r.sublevel = stll_pkg::TOP_SUBLEVEL;
    r.overflow = '0;
    if (lvl < stll_pkg::TOP_LEVEL) begin
      cur = thresh_shadow[tab][lvl];
      nxt = thresh_shadow[tab][lvl + 7'd1];
      r.distance = nxt - qv;
      if (nxt != cur) begin
        num = (qv - cur) * stll_pkg::SUBLEVEL_MUL;
        den = nxt - cur;
        // -2^31 / -1 wraps back to -2^31
        if (num == 32'h8000_0000 && den == 32'hFFFF_FFFF) r.sublevel = 32'h8000_0000;
        else r.sublevel = $signed(num) / $signed(den);
      end else begin
        r.sublevel = '0;
      end
    end
    if (lvl > 0) r.overflow = qv - thresh_shadow[tab][lvl - 7'd1];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d expected %0d", $realtime, what,
             $signed(got), $signed(want));
  endtask

  // Driver: bursts of beats separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic accepted;
    logic next_start;
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      accepted = start && !busy;
      next_start = start && !accepted;
      if (accepted) begin
        idle_cycles = 0;
        if (req_i.operation == stll_pkg::OP_LOAD) begin
          thresh_shadow[req_i.table_select][req_i.entry_index] = req_i.entry_value;
          load_count++;
        end else begin
          expected_levels.push_back(classify_value(req_i.table_select, req_i.query_value));
          query_count++;
        end
      end
      if (!next_start) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_beats.size() > 0) begin
          next_start = 1'b1;
          req_i <= pending_beats.pop_front();
          burst_left--;
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction
  always @(posedge clk_i) begin
    stll_pkg::rsp_t want;
    if (rst_ni && result_valid_o) begin
      idle_cycles = 0;
      result_count++;
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected result level", 32'(rsp_o.level), 32'd0);
      end else begin
        want = expected_levels.pop_front();
        if (rsp_o.level !== want.level)
          report_mismatch("level", 32'(rsp_o.level), 32'(want.level));
        if (rsp_o.distance !== want.distance)
          report_mismatch("distance", rsp_o.distance, want.distance);
        if (rsp_o.sublevel !== want.sublevel)
          report_mismatch("sublevel", rsp_o.sublevel, want.sublevel);
        if (rsp_o.overflow !== want.overflow)
          report_mismatch("overflow", rsp_o.overflow, want.overflow);
      end
    end
  end

  // Watchdog on cycles without any accepted beat or checked result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
        $display("** sorted_table_level_lookup: FAILED **");
        $finish;
      end
    end
  end

  function automatic stll_pkg::req_t load_beat(input int tab, input int idx,
                                               input logic [31:0] val);
    stll_pkg::req_t b;
    b = '0;
    b.operation = stll_pkg::OP_LOAD;
    b.table_select = 3'(tab);
    b.entry_index = 7'(idx);
    b.entry_value = val;
    b.query_value = $urandom();
    return b;
  endfunction

  function automatic stll_pkg::req_t query_beat(input int tab, input logic [31:0] val);
    stll_pkg::req_t b;
    b = '0;
    b.operation = stll_pkg::OP_QUERY;
    b.table_select = 3'(tab);
    b.entry_index = 7'($urandom());
    b.entry_value = $urandom();
    b.query_value = val;
    return b;
  endfunction

  // Stimulus and end of run
  initial begin
    int live_tabs[4];
    int tab;
    int pick;
    int idx;
    longint acc;
    logic [31:0] qv;
    live_tabs = '{1, 2, 5, 6};

    // Preload the queried tables: full range, duplicates, dense, all equal
    for (int i = 0; i < stll_pkg::TABLE_LEN; i++) begin
      acc = -64'sd2147483648 + longint'(i) * 64'sd33554432 + $urandom_range(0, 1000);
      thresh_plan[1][i] = (i == 0) ? 32'h8000_0000 :
                          (i == stll_pkg::TABLE_LEN - 1) ? 32'h7FFF_FFFF : acc[31:0];
      thresh_plan[2][i] = 32'((i / 4) * 7 - 200);
      thresh_plan[5][i] = (i == 0) ? -32'sd50 : thresh_plan[5][i - 1] + $urandom_range(0, 3);
      thresh_plan[6][i] = 32'd100;
    end
    foreach (live_tabs[t])
      for (int i = 0; i < stll_pkg::TABLE_LEN; i++)
        pending_beats.push_back(load_beat(live_tabs[t], i, thresh_plan[live_tabs[t]][i]));

    // Directed queries: field extremes, exact thresholds, top and bottom levels
    pending_beats.push_back(query_beat(1, 32'h8000_0000));
    pending_beats.push_back(query_beat(1, 32'h7FFF_FFFF));
    pending_beats.push_back(query_beat(1, 32'd0));
    pending_beats.push_back(query_beat(1, thresh_plan[1][64]));
    pending_beats.push_back(query_beat(1, thresh_plan[1][98]));
    pending_beats.push_back(query_beat(1, thresh_plan[1][99] - 1));
    pending_beats.push_back(query_beat(2, -32'sd1000));
    pending_beats.push_back(query_beat(2, 32'd5));
    pending_beats.push_back(query_beat(2, thresh_plan[2][10]));
    pending_beats.push_back(query_beat(5, thresh_plan[5][40] + 1));
    pending_beats.push_back(query_beat(5, 32'h7FFF_FFFF));
    pending_beats.push_back(query_beat(6, 32'd100));
    pending_beats.push_back(query_beat(6, 32'd99));
    // Descending pair at the bottom of a table: forces -2^31 / -1 in the fraction
    pending_beats.push_back(load_beat(6, 1, 32'd99));
    thresh_plan[6][1] = 32'd99;
    pending_beats.push_back(query_beat(6, 32'h8000_0064));
    // Loads into tables that are never queried
    pending_beats.push_back(load_beat(7, 127, 32'hFFFF_FFFF));
    pending_beats.push_back(load_beat(0, 0, 32'h0000_0000));

    // Random mix: mostly queries, random or steered near thresholds, some reloads
    for (int n = 0; n < 520; n++) begin
      pick = $urandom_range(0, 99);
      tab = live_tabs[$urandom_range(0, 3)];
      idx = $urandom_range(0, stll_pkg::TABLE_LEN - 1);
      if (pick < 5) begin
        pending_beats.push_back(load_beat(($urandom_range(0, 1) ? 3 : 4) ^ $urandom_range(0, 3) & 7,
                                          idx, $urandom()));
      end else if (pick < 28) begin
        qv = ($urandom_range(0, 1)) ? $urandom() : thresh_plan[tab][idx] + $urandom_range(0, 9) - 4;
        thresh_plan[tab][idx] = qv;
        pending_beats.push_back(load_beat(tab, idx, qv));
      end else begin
        case ($urandom_range(0, 5))
          0, 1: qv = $urandom();
          2, 3: qv = thresh_plan[tab][idx] + $urandom_range(0, 4) - 2;
          4: qv = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          default: qv = thresh_plan[tab][idx] +
                        ((thresh_plan[tab][(idx + 1) % stll_pkg::TABLE_LEN] -
                          thresh_plan[tab][idx]) >> 1);
        endcase
        pending_beats.push_back(query_beat(tab, qv));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_beats.size() == 0 && !start && expected_levels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d loads and %0d queries, %0d results checked", load_count,
             query_count, result_count);
    $display("tables queried: 1 2 5 6 (wide, duplicated, dense, flat); %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && expected_levels.size() == 0) begin
      $display("** sorted_table_level_lookup: PASSED **");
    end else begin
      $display("** sorted_table_level_lookup: FAILED **");
    end
    $finish;
  end

endmodule
